>>> sv/pit_square_wave_synth_top_macros.svh
// ----------------------------------------------------------------------------
// pit_square_wave_synth_top_macros.svh
// Assertion macros for the square wave synthesizer; empty when assertions are off.
// ----------------------------------------------------------------------------
`ifndef PIT_SQUARE_WAVE_SYNTH_TOP_MACROS_SVH
`define PIT_SQUARE_WAVE_SYNTH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define PSWS_ASSERT_IMPL(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("psws assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define PSWS_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("psws assertion failed");
`else
`define PSWS_ASSERT_IMPL(label, lhs, rhs)
`define PSWS_ASSERT_NEXT(label, lhs, rhs)
`endif

`endif

>>> sv/psws_pkg.sv
// ----------------------------------------------------------------------------
// psws_pkg
// Shared types and constants of the timer square wave synthesizer.
// ----------------------------------------------------------------------------
package psws_pkg;

	localparam int DIV_W   = 16;
	localparam int AMP_W   = 15;
	localparam int SMP_W   = 16;
	localparam int PHASE_W = 32;

	localparam logic [AMP_W-1:0] AMP_RESET = 15'd8192;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> sv/pit_square_wave_synth_top.sv
// ----------------------------------------------------------------------------
// pit_square_wave_synth_top
// Square wave tone synthesizer driven by a timer divisor, one sample per request.
// ----------------------------------------------------------------------------
// channel  | direction | tdata            | tuser    | tlast
// s_*      | in        | [15:0] divisor   | gate_on  | chunk_last
// m_*      | out       | [15:0] sample    | -        | end_of_chunk
// cfg_*    | in        | [14:0] amplitude | -        | -
//
// A tone request waits on the bit-serial divider computing the phase step;
// a silent request (gate off or divisor zero) skips the divider.
// One request is in work at a time; the output register holds a finished
// sample while the next request is taken, and a stalled output holds the
// next finished request until the slot frees. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "pit_square_wave_synth_top_macros.svh"

module pit_square_wave_synth_top #(
	parameter int TIMER_CLOCK_HZ = 1193182,
	parameter int OUTPUT_RATE_HZ = 48000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] divisor
	input  logic        s_tuser,    // [0] gate_on
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] sample
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata
);

	localparam int PW = psws_pkg::PHASE_W;
	localparam int SW = psws_pkg::SMP_W;

	psws_pkg::state_t    state_q, state_d;
	psws_pkg::div_stat_t div_st;

	logic [PW-1:0]              phase_q;
	logic [PW-1:0]              step;
	logic [psws_pkg::AMP_W-1:0] amp_q;
	logic [SW-1:0]              smp_q;
	logic                       last_q;
	logic [SW-1:0]              m_smp_q;
	logic                       m_last_q;
	logic                       m_valid_q;

	logic accept;
	logic tone;
	logic div_start;
	logic load_out;
	logic [SW-1:0] smp_pos;

	assign accept  = s_tvalid && s_tready;
	assign tone    = s_tuser && (s_tdata != 16'd0);
	assign smp_pos = {1'b0, amp_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psws_pkg::ST_IDLE: begin
				if (accept) state_d = tone ? psws_pkg::ST_DIV : psws_pkg::ST_HOLD;
			end
			psws_pkg::ST_DIV: begin
				if (div_st.done) state_d = psws_pkg::ST_HOLD;
			end
			psws_pkg::ST_HOLD: begin
				if (!m_valid_q || m_tready) state_d = psws_pkg::ST_IDLE;
			end
			default: state_d = psws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == psws_pkg::ST_IDLE);
		div_start = (state_q == psws_pkg::ST_IDLE) && s_tvalid && tone;
		load_out  = (state_q == psws_pkg::ST_HOLD) && (!m_valid_q || m_tready);
	end

	psws_step_div #(
		.TIMER_CLOCK_HZ(TIMER_CLOCK_HZ),
		.OUTPUT_RATE_HZ(OUTPUT_RATE_HZ)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.divisor(s_tdata),
		.stat   (div_st),
		.step   (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= psws_pkg::ST_IDLE;
			phase_q   <= '0;
			amp_q     <= psws_pkg::AMP_RESET;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) amp_q <= cfg_wdata;
			// advance the phase once the step is ready, wrapping modulo one waveform period
			if ((state_q == psws_pkg::ST_DIV) && div_st.done) phase_q <= phase_q + step;
			if (load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= s_tlast;
			// sample from the phase before this request's advance
			if (!tone) smp_q <= '0;
			else if (phase_q[PW-1]) smp_q <= SW'(0) - smp_pos;
			else smp_q <= smp_pos;
		end
		if (load_out) begin
			m_smp_q  <= smp_q;
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_smp_q;
	assign m_tlast  = m_last_q;

	`PSWS_ASSERT_IMPL(a_idle_div_free, s_tready, !div_st.busy)
	`PSWS_ASSERT_IMPL(a_done_in_div, div_st.done, state_q == psws_pkg::ST_DIV)
	`PSWS_ASSERT_NEXT(a_phase_hold, !div_st.done, $stable(phase_q))

endmodule

>>> sv/psws_step_div.sv
// ----------------------------------------------------------------------------
// psws_step_div
// Bit-serial restoring divider: step = (timer clock << 32) / (divisor * rate).
// ----------------------------------------------------------------------------
module psws_step_div #(
	parameter int TIMER_CLOCK_HZ = 1193182,
	parameter int OUTPUT_RATE_HZ = 48000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psws_pkg::DIV_W-1:0]    divisor,
	output psws_pkg::div_stat_t           stat,
	output logic [psws_pkg::PHASE_W-1:0]  step
);

	localparam int TW = $clog2(TIMER_CLOCK_HZ + 1);
	localparam int RW = $clog2(OUTPUT_RATE_HZ + 1);
	localparam int DW = psws_pkg::DIV_W + RW;
	localparam int QW = psws_pkg::PHASE_W;
	localparam int NW = TW + QW;
	localparam int CW = $clog2(NW + 1);

	localparam logic [DW-1:0] RATE_C = DW'(OUTPUT_RATE_HZ);
	localparam logic [NW-1:0] NUM_C  = {TW'(TIMER_CLOCK_HZ), {QW{1'b0}}};

	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          qbit;

	// shift in the next numerator bit and try one subtract
	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = !diff[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= DW'(divisor) * RATE_C;
			rem_q <= '0;
			num_q <= NUM_C;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign step      = quo_q;

endmodule

>>> tb/sv/pit_square_wave_synth_top_test.sv
// ----------------------------------------------------------------------------
// pit_square_wave_synth_top_test
// Self-checking bench for the timer square wave synthesizer. A predictor in
// the bench tracks the phase and amplitude, queues the expected sample for
// every accepted request and compares each output sample as it leaves the
// block. Directed tone and silence cases come first. Random chunks of tones
// and noise follow under several amplitudes with random idling on both sides,
// then a long output stall fills the block.
// ----------------------------------------------------------------------------
module pit_square_wave_synth_top_test;

	localparam int unsigned TIMER_HZ    = 1193182;
	localparam int unsigned OUT_HZ      = 48000;
	localparam int          TONE_LAT    = 70;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          MAX_REPORTS = 10;

	typedef struct packed {
		logic [psws_pkg::SMP_W-1:0] sample;
		logic                       eoc;
	} pcm_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [psws_pkg::DIV_W-1:0] s_tdata;
	logic                       s_tuser;
	logic                       s_tlast;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [psws_pkg::SMP_W-1:0] m_tdata;
	logic                       m_tlast;
	logic                       cfg_we;
	logic [psws_pkg::AMP_W-1:0] cfg_wdata;

	// predictor state
	logic [psws_pkg::PHASE_W-1:0] phase_acc = '0;
	logic [psws_pkg::AMP_W-1:0]   amp_cur   = psws_pkg::AMP_RESET;
	pcm_t                         pcm_exp_q[$];
	pcm_t                         pcm_head;

	int n_fail      = 0;
	int tx_idle_en  = 1;
	int rx_idle_en  = 1;
	int stall_req   = 0;
	int stall_left  = 0;
	int rx_gap      = 0;

	pit_square_wave_synth_top #(
		.TIMER_CLOCK_HZ(TIMER_HZ),
		.OUTPUT_RATE_HZ(OUT_HZ)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic pcm_t predict_tone(input logic [psws_pkg::DIV_W-1:0] div,
			input logic gate, input logic last);
		pcm_t        r;
		logic [63:0] num;
		logic [63:0] den;
		r.eoc    = last;
		r.sample = '0;
		if (gate && div != '0) begin
			if (!phase_acc[psws_pkg::PHASE_W-1])
				r.sample = {1'b0, amp_cur};
			else
				r.sample = 16'd0 - {1'b0, amp_cur};
			num = 64'(TIMER_HZ) << 32;
			den = 64'(div) * 64'(OUT_HZ);
			// whole cycles drop out with the truncation to the phase width
			phase_acc = phase_acc + psws_pkg::PHASE_W'(num / den);
		end
		return r;
	endfunction

	function automatic int pick_tx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 4);
		if (r < 98) return $urandom_range(5, 20);
		return $urandom_range(30, 80);
	endfunction

	function automatic int pick_rx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [psws_pkg::DIV_W-1:0] pick_divisor();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return psws_pkg::DIV_W'($urandom_range(1, 255));
		if (r < 70) return psws_pkg::DIV_W'($urandom_range(256, 4095));
		return psws_pkg::DIV_W'($urandom_range(0, 65535));
	endfunction

	// compare leaving samples, then record config writes and new requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pcm_exp_q.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("unexpected sample %0d last %0b", $signed(m_tdata), m_tlast);
				end else begin
					pcm_head = pcm_exp_q.pop_front();
					if (pcm_head.sample !== m_tdata || pcm_head.eoc !== m_tlast) begin
						n_fail++;
						if (n_fail <= MAX_REPORTS)
							$display("sample mismatch: expected %0d last %0b, got %0d last %0b",
								$signed(pcm_head.sample), pcm_head.eoc,
								$signed(m_tdata), m_tlast);
					end
				end
			end
			if (cfg_we)
				amp_cur = cfg_wdata;
			if (s_tvalid && s_tready)
				pcm_exp_q.push_back(predict_tone(s_tdata, s_tuser, s_tlast));
		end
	end

	// output side: random gaps plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req > 0) begin
				stall_left = stall_req;
				stall_req  = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en != 0 && $urandom_range(0, 3) == 0)
					rx_gap = pick_rx_gap();
			end
		end
	end

	task automatic send_tone(input logic [psws_pkg::DIV_W-1:0] div, input logic gate,
			input logic last);
		int gap;
		gap = (tx_idle_en != 0) ? pick_tx_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= div;
		s_tuser  <= gate;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid, wait for every sample, then let the divider settle
	task automatic drain_samples();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pcm_exp_q.size() == 0);
		repeat (TONE_LAT) @(posedge clk);
	endtask

	task automatic write_amplitude(input logic [psws_pkg::AMP_W-1:0] amp);
		drain_samples();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= amp;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic test_reset_amplitude();
		send_tone(16'd0, 1'b1, 1'b0);       // divisor zero is silence
		send_tone(16'd100, 1'b0, 1'b1);     // gate off is silence
		send_tone(16'd1, 1'b1, 1'b0);       // step of many cycles wraps
		send_tone(16'd1, 1'b1, 1'b0);
		send_tone(16'd2, 1'b1, 1'b0);
		send_tone(16'hFFFF, 1'b1, 1'b1);
		send_tone(16'h5555, 1'b1, 1'b0);
		send_tone(16'hAAAA, 1'b1, 1'b0);
		send_tone(16'h8000, 1'b1, 1'b1);
	endtask

	task automatic test_amplitude_extremes();
		write_amplitude(15'h7FFF);
		for (int i = 0; i < 4; i++)
			send_tone(16'd20, 1'b1, i == 3);
		// zero amplitude: silent output, phase still advances
		write_amplitude(15'd0);
		for (int i = 0; i < 3; i++)
			send_tone(16'd20, 1'b1, 1'b0);
		send_tone(16'd0, 1'b0, 1'b1);
		write_amplitude(15'd1);
		for (int i = 0; i < 3; i++)
			send_tone(16'd3, 1'b1, i == 2);
	endtask

	task automatic test_random_chunks(input logic [psws_pkg::AMP_W-1:0] amp, input int n_items);
		int                         sent;
		int                         len;
		logic [psws_pkg::DIV_W-1:0] div;
		write_amplitude(amp);
		sent = 0;
		while (sent < n_items) begin
			tx_idle_en = int'($urandom_range(0, 4) != 0);
			rx_idle_en = int'($urandom_range(0, 4) != 0);
			len = $urandom_range(1, 24);
			if ($urandom_range(0, 99) < 80) begin
				// steady tone over one chunk
				div = pick_divisor();
				for (int i = 0; i < len; i++)
					send_tone(div, 1'b1, i == len - 1);
			end else begin
				for (int i = 0; i < len; i++)
					send_tone(psws_pkg::DIV_W'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			sent += len;
		end
		tx_idle_en = 1;
		rx_idle_en = 1;
	endtask

	task automatic test_output_backpressure();
		drain_samples();
		tx_idle_en = 0;
		@(posedge clk);
		stall_req = 400;
		for (int i = 0; i < 20; i++)
			send_tone(psws_pkg::DIV_W'($urandom_range(1, 500)), 1'b1, i == 19);
		tx_idle_en = 1;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_amplitude();
		test_amplitude_extremes();
		test_random_chunks(15'h7FFF, 150);
		test_random_chunks(psws_pkg::AMP_W'($urandom_range(0, 32767)), 150);
		test_random_chunks(15'd0, 150);
		test_random_chunks(psws_pkg::AMP_W'($urandom_range(1, 32767)), 150);
		test_output_backpressure();

		drain_samples();
		if (n_fail == 0 && pcm_exp_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
